### hw/rtl/alr_pkg.sv
// Shared types and constants for the antialiased line rasterizer.
// No dependencies; every other file imports this package.
package alr_pkg;

	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 24;
	localparam int ALPHA_BITS = 8;
	localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = 8'd255;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef struct packed {
		logic                         op;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [COLOR_BITS-1:0]        rgb;
	} alr_cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0]     pixel_x;
		logic signed [COORD_BITS-1:0]     pixel_y;
		logic [ALPHA_BITS+COLOR_BITS-1:0] argb;
		logic                             last;
	} alr_pix_t;

	typedef struct packed {
		logic latch;
		logic order;
		logic div_step;
		logic div_done;
		logic emit0;
		logic emit1;
	} alr_ctl_t;

	typedef struct packed {
		logic active;
		logic out_free;
	} alr_sts_t;

endpackage

### hw/rtl/alr_datapath.sv
// Datapath: line setup, restoring slope divider, column stepper and output register.
// Depends on alr_pkg; driven by alr_controller through alr_ctl_t.
module alr_datapath import alr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  alr_cmd_t cmd,
	input  alr_ctl_t ctl,
	output alr_sts_t sts,
	output logic     pix_valid,
	input  logic     pix_ready,
	output alr_pix_t pix
);
	localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
	localparam int SLOPE_BITS = ACC_BITS + 1;
	localparam int PROD_BITS = FRAC_BITS + 1 + ALPHA_BITS;

	logic signed [COORD_BITS-1:0] a_maj_q, a_min_q, b_maj_q, b_min_q;
	logic                         steep_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic [COORD_BITS-1:0]        cur_q, end_q;
	logic [ACC_BITS-1:0]          acc_q;
	logic [SLOPE_BITS-1:0]        slope_q;
	logic [COORD_BITS:0]          rem_q;
	logic [COORD_BITS-1:0]        dx_q;
	logic [FRAC_BITS:0]           quo_q;
	logic                         neg_q, zero_q, active_q;
	alr_pix_t                     pix_q;
	logic                         pix_valid_q;

	logic signed [COORD_BITS:0]   dxr, dyr, dxo, dyo;
	logic [COORD_BITS:0]          adx, ady, ady_o;
	logic                         steep, swap;
	logic signed [COORD_BITS-1:0] bmaj, bmin, emaj, emin;
	logic                         ge;
	logic [COORD_BITS:0]          diff;
	logic [FRAC_BITS:0]           quo_next;
	logic [SLOPE_BITS-1:0]        mag;
	logic [FRAC_BITS-1:0]         frac;
	logic [FRAC_BITS:0]           inv;
	logic [PROD_BITS-1:0]         prod0, prod1;
	logic [COORD_BITS-1:0]        m0, m1;
	logic                         fin;
	alr_pix_t                     p0, p1;

	always_comb begin
		dxr = (COORD_BITS+1)'(cmd.end_x) - (COORD_BITS+1)'(cmd.start_x);
		dyr = (COORD_BITS+1)'(cmd.end_y) - (COORD_BITS+1)'(cmd.start_y);
		adx = dxr[COORD_BITS] ? (COORD_BITS+1)'(-dxr) : dxr;
		ady = dyr[COORD_BITS] ? (COORD_BITS+1)'(-dyr) : dyr;
		steep = ady > adx;

		swap = a_maj_q > b_maj_q;
		bmaj = swap ? b_maj_q : a_maj_q;
		bmin = swap ? b_min_q : a_min_q;
		emaj = swap ? a_maj_q : b_maj_q;
		emin = swap ? a_min_q : b_min_q;
		dxo = (COORD_BITS+1)'(emaj) - (COORD_BITS+1)'(bmaj);
		dyo = (COORD_BITS+1)'(emin) - (COORD_BITS+1)'(bmin);
		ady_o = dyo[COORD_BITS] ? (COORD_BITS+1)'(-dyo) : dyo;

		ge = rem_q >= {1'b0, dx_q};
		diff = ge ? rem_q - {1'b0, dx_q} : rem_q;
		quo_next = {quo_q[FRAC_BITS-1:0], ge};
		mag = SLOPE_BITS'(quo_next);

		frac = acc_q[FRAC_BITS-1:0];
		inv = (FRAC_BITS+1)'(1) << FRAC_BITS;
		inv = inv - {1'b0, frac};
		prod0 = PROD_BITS'(inv) * PROD_BITS'(ALPHA_MAX);
		prod1 = PROD_BITS'(frac) * PROD_BITS'(ALPHA_MAX);
		m0 = acc_q[ACC_BITS-1:FRAC_BITS];
		m1 = m0 + COORD_BITS'(1);
		fin = cur_q == end_q;

		p0.pixel_x = steep_q ? m0 : cur_q;
		p0.pixel_y = steep_q ? cur_q : m0;
		p0.argb = {prod0[FRAC_BITS+ALPHA_BITS-1:FRAC_BITS], color_q};
		p0.last = 1'b0;
		p1.pixel_x = steep_q ? m1 : cur_q;
		p1.pixel_y = steep_q ? cur_q : m1;
		p1.argb = {prod1[FRAC_BITS+ALPHA_BITS-1:FRAC_BITS], color_q};
		p1.last = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pix_valid_q <= 1'b0;
			steep_q <= 1'b0;
			color_q <= '0;
			cur_q <= '0;
			end_q <= '0;
			acc_q <= '0;
			slope_q <= '0;
		end else begin
			if (ctl.latch) begin
				steep_q <= steep;
				color_q <= cmd.rgb;
			end
			if (ctl.order) begin
				cur_q <= bmaj;
				end_q <= emaj;
				acc_q <= {bmin, {FRAC_BITS{1'b0}}};
				active_q <= 1'b1;
			end
			if (ctl.div_done) begin
				if (zero_q) begin
					slope_q <= SLOPE_BITS'(1) << FRAC_BITS;
				end else if (neg_q) begin
					slope_q <= SLOPE_BITS'(-mag);
				end else begin
					slope_q <= mag;
				end
			end
			if (ctl.emit1) begin
				if (fin) begin
					active_q <= 1'b0;
				end else begin
					cur_q <= cur_q + COORD_BITS'(1);
					acc_q <= acc_q + slope_q[ACC_BITS-1:0];
				end
			end
			if (ctl.emit0 || ctl.emit1) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			a_maj_q <= steep ? cmd.start_y : cmd.start_x;
			a_min_q <= steep ? cmd.start_x : cmd.start_y;
			b_maj_q <= steep ? cmd.end_y : cmd.end_x;
			b_min_q <= steep ? cmd.end_x : cmd.end_y;
		end
		if (ctl.order) begin
			dx_q <= dxo[COORD_BITS-1:0];
			rem_q <= ady_o;
			neg_q <= dyo[COORD_BITS];
			zero_q <= dxo == '0;
			quo_q <= '0;
		end
		if (ctl.div_step) begin
			rem_q <= {diff[COORD_BITS-1:0], 1'b0};
			quo_q <= quo_next;
		end
		if (ctl.emit0) begin
			pix_q <= p0;
		end else if (ctl.emit1) begin
			pix_q <= p1;
		end
	end

	assign sts.active = active_q;
	assign sts.out_free = !pix_valid_q || pix_ready;
	assign pix_valid = pix_valid_q;
	assign pix = pix_q;

endmodule

### hw/rtl/alr_controller.sv
// Controller state machine: sequences load setup, slope division and pixel emission.
// Depends on alr_pkg; drives alr_datapath through alr_ctl_t.
module alr_controller import alr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  logic     cmd_op,
	output logic     cmd_ready,
	input  alr_sts_t sts,
	output alr_ctl_t ctl
);
	localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_PIX1
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                accept;

	assign cmd_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept = cmd_valid && cmd_ready;

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.latch = accept && (cmd_op == OP_LOAD);
				ctl.emit0 = accept && (cmd_op == OP_STEP) && sts.active;
			end
			ST_SETUP: begin
				ctl.order = 1'b1;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				ctl.div_done = cnt_q == '0;
			end
			ST_PIX1: begin
				ctl.emit1 = sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.latch) begin
						state_q <= ST_SETUP;
					end else if (ctl.emit0) begin
						state_q <= ST_PIX1;
					end
				end
				ST_SETUP: begin
					cnt_q <= CNT_BITS'(FRAC_BITS);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
				ST_PIX1: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/antialiased_line_rasterizer.sv
// Top level of the antialiased line rasterizer: controller plus datapath.
// Depends on alr_pkg, alr_controller and alr_datapath.
//
//   port   direction  payload     beat
//   cmd    in         alr_cmd_t   load a line or step one column
//   pix    out        alr_pix_t   one pixel with alpha and color
//
// A step beat of an active line gives two pixel beats; the next cmd beat waits until both are issued.
// A load beat runs the line setup, then the one-bit-per-cycle slope divider, before the next cmd beat is taken.
// A step with no active line is taken and gives nothing; the controller stays idle.
// Reset clears the controller and the active flag; no line is loaded after it.
// A stalled pix port holds the pixel and stops new cmd beats.
module antialiased_line_rasterizer import alr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  alr_cmd_t cmd,
	output logic     pix_valid,
	input  logic     pix_ready,
	output alr_pix_t pix
);
	alr_ctl_t ctl;
	alr_sts_t sts;

	alr_controller #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_op   (cmd.op),
		.cmd_ready(cmd_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	alr_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.ctl      (ctl),
		.sts      (sts),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix)
	);

endmodule

### hw/rtl/alr_checker.sv
// Port-level checks of the antialiased line rasterizer, bound to the top level.
// Depends on alr_pkg and antialiased_line_rasterizer.
module alr_checker import alr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_ready,
	input alr_cmd_t cmd,
	input logic     pix_valid,
	input logic     pix_ready,
	input alr_pix_t pix
);

	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("Stalled pixel beat changed or dropped.");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.op == OP_LOAD) |=> !cmd_ready)
		else $error("Command taken during line setup.");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.op == OP_LOAD) |=> !pix_valid)
		else $error("Pixel beat pending after a load.");

	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix.last |=> !pix_valid)
		else $error("Pixel emitted right after the final column.");

endmodule

bind antialiased_line_rasterizer alr_checker u_alr_checker (.*);
